// File: design/sawh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sawh_pkg;

    // Request modes carried in the mode field.
    localparam logic [2:0] MODE_SEND   = 3'd0;
    localparam logic [2:0] MODE_HBEAT  = 3'd1;
    localparam logic [2:0] MODE_RX     = 3'd2;
    localparam logic [2:0] MODE_REPORT = 3'd3;
    localparam logic [2:0] MODE_POLL   = 3'd4;

    // Configuration register indexes and their reset values.
    localparam logic REG_HBEAT_INTERVAL = 1'b0;
    localparam logic REG_DEFAULT_SP     = 1'b1;
    localparam logic [31:0] HBEAT_INTERVAL_RESET = 32'd1000;
    localparam logic [31:0] DEFAULT_SP_RESET     = 32'd0;

    // Status flag bit positions and reset value.
    localparam int FLAG_OK      = 0;
    localparam int FLAG_PENDING = 1;
    localparam int FLAG_TEMP    = 2;
    localparam int FLAG_FLOW    = 3;
    localparam logic [3:0] FLAGS_RESET = 4'b0001;

    typedef struct packed {
        logic [31:0] hbeat_interval;
        logic [31:0] default_sp;
        logic        default_sp_wr;
        logic [31:0] wdata;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now_ms;
        logic [31:0] setpoint_word;
        logic        run_request;
        logic        link_ok;
        logic [15:0] rx_seq;
        logic        rx_ack;
        logic        rx_temp_valid;
        logic        rx_flow_valid;
        logic [31:0] rx_temp_word;
        logic [31:0] rx_flow_word;
        logic        rx_well_formed;
    } item_t;

    typedef struct packed {
        logic        send_valid;
        logic [15:0] tx_seq;
        logic [31:0] tx_time_ms;
        logic [31:0] tx_setpoint_word;
        logic        tx_run;
        logic        accepted;
        logic [15:0] last_seq;
        logic [31:0] close_count;
        logic [3:0]  status_bits;
        logic [31:0] outlet_temp_word;
        logic [31:0] flow_word;
        logic        status_new;
    } result_t;

endpackage

`default_nettype wire

// File: design/stop_and_wait_sender_with_heartbeat.sv
`timescale 1ns / 1ps
`default_nettype none

// Stop-and-wait frame sender with a heartbeat, keeping one frame in flight.
// Request channel: in_valid / in_stall with one request per accepted edge;
// the mode field selects user setpoint send, heartbeat tick, received frame,
// transmit report or status poll. Result channel: out_valid / out_stall,
// exactly one result for each request, in order.
// A request goes through one input register, then the decision logic into
// the result register. A new request is taken in every cycle while the
// result side keeps up, so throughput is one request per cycle; the sender
// state is read and written by one request per cycle.
// When the receiver stalls, the result register holds its value and the
// input register fills; in_stall then rises until the result is taken.
// Reset clears both registers, leaves nothing in flight, sets sequence and
// count to zero and the status to last-ok. The heartbeat interval and the
// default setpoint must be written over the APB port only while no request
// is in work; the block itself does not enforce this.
module stop_and_wait_sender_with_heartbeat (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Request channel.
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] now_ms,
    input  wire logic [31:0] setpoint_word,
    input  wire logic        run_request,
    input  wire logic        link_ok,
    input  wire logic [15:0] rx_seq,
    input  wire logic        rx_ack,
    input  wire logic        rx_temp_valid,
    input  wire logic        rx_flow_valid,
    input  wire logic [31:0] rx_temp_word,
    input  wire logic [31:0] rx_flow_word,
    input  wire logic        rx_well_formed,
    // Result channel.
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             send_valid,
    output logic [15:0]      tx_seq,
    output logic [31:0]      tx_time_ms,
    output logic [31:0]      tx_setpoint_word,
    output logic             tx_run,
    output logic             accepted,
    output logic [15:0]      last_seq,
    output logic [31:0]      close_count,
    output logic [3:0]       status_bits,
    output logic [31:0]      outlet_temp_word,
    output logic [31:0]      flow_word,
    output logic             status_new
);

    sawh_pkg::cfg_t    cfg;
    sawh_pkg::item_t   in_item;
    sawh_pkg::item_t   item_reg;
    sawh_pkg::result_t res;
    sawh_pkg::result_t res_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg;
    logic              advance;
    logic              in_take;

    sawh_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Gather the request fields.
    assign in_item.mode           = mode;
    assign in_item.now_ms         = now_ms;
    assign in_item.setpoint_word  = setpoint_word;
    assign in_item.run_request    = run_request;
    assign in_item.link_ok        = link_ok;
    assign in_item.rx_seq         = rx_seq;
    assign in_item.rx_ack         = rx_ack;
    assign in_item.rx_temp_valid  = rx_temp_valid;
    assign in_item.rx_flow_valid  = rx_flow_valid;
    assign in_item.rx_temp_word   = rx_temp_word;
    assign in_item.rx_flow_word   = rx_flow_word;
    assign in_item.rx_well_formed = rx_well_formed;

    // The held request moves on whenever the result register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall      = in_valid_reg && !advance;
    assign in_take       = in_valid && !in_stall;
    assign in_valid_next = in_take || (in_valid_reg && !advance);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_item;
        end
    end

    sawh_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (item_reg),
        .res     (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign send_valid       = res_reg.send_valid;
    assign tx_seq           = res_reg.tx_seq;
    assign tx_time_ms       = res_reg.tx_time_ms;
    assign tx_setpoint_word = res_reg.tx_setpoint_word;
    assign tx_run           = res_reg.tx_run;
    assign accepted         = res_reg.accepted;
    assign last_seq         = res_reg.last_seq;
    assign close_count      = res_reg.close_count;
    assign status_bits      = res_reg.status_bits;
    assign outlet_temp_word = res_reg.outlet_temp_word;
    assign flow_word        = res_reg.flow_word;
    assign status_new       = res_reg.status_new;

endmodule

`default_nettype wire

// File: design/sawh_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sawh_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sawh_pkg::cfg_t    cfg
);

    logic [31:0] hbeat_interval_reg;
    logic [31:0] default_sp_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hbeat_interval_reg <= sawh_pkg::HBEAT_INTERVAL_RESET;
            default_sp_reg     <= sawh_pkg::DEFAULT_SP_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == sawh_pkg::REG_HBEAT_INTERVAL)
            begin
                hbeat_interval_reg <= pwdata;
            end
            else
            begin
                default_sp_reg <= pwdata;
            end
        end
    end

    // Read data selection.
    always_comb
    begin
        if (reg_sel == sawh_pkg::REG_HBEAT_INTERVAL)
        begin
            prdata = hbeat_interval_reg;
        end
        else
        begin
            prdata = default_sp_reg;
        end
    end

    // The default setpoint write is passed on so the held setpoint can follow it.
    assign cfg.hbeat_interval = hbeat_interval_reg;
    assign cfg.default_sp     = default_sp_reg;
    assign cfg.default_sp_wr  = wr_en && (reg_sel == sawh_pkg::REG_DEFAULT_SP);
    assign cfg.wdata          = pwdata;

endmodule

`default_nettype wire

// File: design/sawh_step.sv
`timescale 1ns / 1ps
`default_nettype none

module sawh_step (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sawh_pkg::cfg_t  cfg,
    input  wire logic            advance,
    input  wire sawh_pkg::item_t item,
    output sawh_pkg::result_t    res
);

    logic [15:0] next_seq_reg,    next_seq_next;
    logic [15:0] flight_seq_reg,  flight_seq_next;
    logic        flight_user_reg, flight_user_next;
    logic [31:0] last_send_reg,   last_send_next;
    logic [31:0] held_sp_reg,     held_sp_next;
    logic        held_run_reg,    held_run_next;
    logic        user_stored_reg, user_stored_next;
    logic [15:0] closed_seq_reg,  closed_seq_next;
    logic [31:0] closed_cnt_reg,  closed_cnt_next;
    logic [3:0]  flags_reg,       flags_next;
    logic [31:0] echo_temp_reg,   echo_temp_next;
    logic [31:0] echo_flow_reg,   echo_flow_next;
    logic        changed_reg,     changed_next;

    logic        idle;
    logic        is_send;
    logic        is_poll;
    logic        hbeat_due;
    logic        send;
    logic        ack_close;
    logic        rep_close;
    logic        send_close;
    logic        any_close;
    logic [15:0] seq_inc;
    logic [15:0] seq;
    logic [31:0] elapsed;
    logic        changed_upd;

    // Decode of the request and the send decision.
    assign idle      = (flight_seq_reg == 16'd0);
    assign is_send   = (item.mode == sawh_pkg::MODE_SEND);
    assign is_poll   = (item.mode == sawh_pkg::MODE_POLL);
    assign elapsed   = item.now_ms - last_send_reg;
    assign hbeat_due = (item.mode == sawh_pkg::MODE_HBEAT) && (elapsed >= cfg.hbeat_interval);
    assign send      = idle && (is_send || hbeat_due);

    // The sequence number skips zero on wrap, since zero marks nothing in flight.
    assign seq_inc = next_seq_reg + 16'd1;
    assign seq     = (seq_inc == 16'd0) ? 16'd1 : seq_inc;

    // Frame close events; at most one of them fires for a request.
    assign ack_close  = (item.mode == sawh_pkg::MODE_RX) && item.rx_well_formed && item.rx_ack
                        && !idle && (item.rx_seq == flight_seq_reg);
    assign rep_close  = (item.mode == sawh_pkg::MODE_REPORT) && !item.link_ok && !idle;
    assign send_close = send && !item.link_ok;
    assign any_close  = ack_close || rep_close || send_close;

    // Next state of the sender.
    always_comb
    begin
        next_seq_next    = next_seq_reg;
        flight_seq_next  = flight_seq_reg;
        flight_user_next = flight_user_reg;
        last_send_next   = last_send_reg;
        held_sp_next     = held_sp_reg;
        held_run_next    = held_run_reg;
        user_stored_next = user_stored_reg;
        closed_seq_next  = closed_seq_reg;
        closed_cnt_next  = closed_cnt_reg;
        flags_next       = flags_reg;
        echo_temp_next   = echo_temp_reg;
        echo_flow_next   = echo_flow_reg;
        changed_upd      = changed_reg;

        if (is_send)
        begin
            held_sp_next     = item.setpoint_word;
            held_run_next    = item.run_request;
            user_stored_next = 1'b1;
        end

        if (ack_close)
        begin
            closed_seq_next = item.rx_seq;
            echo_temp_next  = item.rx_temp_word;
            echo_flow_next  = item.rx_flow_word;
            flags_next[sawh_pkg::FLAG_OK] = 1'b1;
            if (flight_user_reg)
            begin
                flags_next[sawh_pkg::FLAG_PENDING] = 1'b0;
            end
            flags_next[sawh_pkg::FLAG_TEMP] = item.rx_temp_valid;
            flags_next[sawh_pkg::FLAG_FLOW] = item.rx_flow_valid;
        end

        if (rep_close)
        begin
            closed_seq_next = flight_seq_reg;
            flags_next[sawh_pkg::FLAG_OK] = 1'b0;
            if (flight_user_reg)
            begin
                flags_next[sawh_pkg::FLAG_PENDING] = 1'b0;
            end
        end

        if (send)
        begin
            next_seq_next  = seq;
            last_send_next = item.now_ms;
            if (item.link_ok)
            begin
                flight_seq_next  = seq;
                flight_user_next = is_send;
                if (is_send)
                begin
                    flags_next[sawh_pkg::FLAG_PENDING] = 1'b1;
                end
            end
            else
            begin
                // Refused at once: the new frame is closed as failed.
                closed_seq_next = seq;
                flags_next[sawh_pkg::FLAG_OK] = 1'b0;
                if (is_send)
                begin
                    flags_next[sawh_pkg::FLAG_PENDING] = 1'b0;
                end
            end
        end

        if (any_close)
        begin
            closed_cnt_next  = closed_cnt_reg + 32'd1;
            flight_seq_next  = 16'd0;
            flight_user_next = 1'b0;
        end

        if (any_close || (send && is_send))
        begin
            changed_upd = 1'b1;
        end

        changed_next = is_poll ? 1'b0 : changed_upd;

        // A default setpoint write must only come while no request is in work; the block does not enforce this.
        if (cfg.default_sp_wr && !user_stored_reg)
        begin
            held_sp_next = cfg.wdata;
        end
    end

    // State registers; a default write is taken whether or not a request advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seq_reg    <= 16'd0;
            flight_seq_reg  <= 16'd0;
            flight_user_reg <= 1'b0;
            last_send_reg   <= 32'd0;
            held_sp_reg     <= sawh_pkg::DEFAULT_SP_RESET;
            held_run_reg    <= 1'b0;
            user_stored_reg <= 1'b0;
            closed_seq_reg  <= 16'd0;
            closed_cnt_reg  <= 32'd0;
            flags_reg       <= sawh_pkg::FLAGS_RESET;
            echo_temp_reg   <= 32'd0;
            echo_flow_reg   <= 32'd0;
            changed_reg     <= 1'b0;
        end
        else if (advance)
        begin
            next_seq_reg    <= next_seq_next;
            flight_seq_reg  <= flight_seq_next;
            flight_user_reg <= flight_user_next;
            last_send_reg   <= last_send_next;
            held_sp_reg     <= held_sp_next;
            held_run_reg    <= held_run_next;
            user_stored_reg <= user_stored_next;
            closed_seq_reg  <= closed_seq_next;
            closed_cnt_reg  <= closed_cnt_next;
            flags_reg       <= flags_next;
            echo_temp_reg   <= echo_temp_next;
            echo_flow_reg   <= echo_flow_next;
            changed_reg     <= changed_next;
        end
        else if (cfg.default_sp_wr && !user_stored_reg)
        begin
            held_sp_reg <= cfg.wdata;
        end
    end

    // Result of the request, with status after its updates.
    assign res.send_valid       = send;
    assign res.tx_seq           = send ? seq : 16'd0;
    assign res.tx_time_ms       = send ? item.now_ms : 32'd0;
    assign res.tx_setpoint_word = send ? held_sp_next : 32'd0;
    assign res.tx_run           = send && held_run_next;
    assign res.accepted         = (send && is_send && item.link_ok) || (is_poll && changed_reg);
    assign res.last_seq         = closed_seq_next;
    assign res.close_count      = closed_cnt_next;
    assign res.status_bits      = flags_next;
    assign res.outlet_temp_word = echo_temp_next;
    assign res.flow_word        = echo_flow_next;
    assign res.status_new       = changed_upd;

endmodule

`default_nettype wire
